// File: rtl/mru_history_list_core_defines.svh
// ---------------------------------------------------------------------------
// mru_history_list_core_defines.svh
// Assertion macros used by the recency list core.
// ---------------------------------------------------------------------------
`ifndef MRU_HISTORY_LIST_CORE_DEFINES_SVH
`define MRU_HISTORY_LIST_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define MHL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define MHL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/mhl_pkg.sv
// ---------------------------------------------------------------------------
// mhl_pkg
// Sizes and types shared by the recency list cells and the core.
// ---------------------------------------------------------------------------
package mhl_pkg;

  // Number of cells in the chain and width of one key
  localparam int DEPTH = 16;
  localparam int KEY_W = 32;

  // Port widths of the beats
  localparam int IN_KEY_W = 32;
  localparam int HPOS_W   = 4;
  localparam int CFG_W    = 5;

  // Derived widths: count holds 0..DEPTH, position indexes one cell
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int POS_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef logic [KEY_W-1:0] key_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [POS_W-1:0] pos_t;

  // Per-cell control: load from the neighbor and the key under search
  typedef struct packed {
    logic load;
    key_t cmp_key;
  } cell_ctl_t;

endpackage

// File: rtl/mhl_cell.sv
// ---------------------------------------------------------------------------
// mhl_cell
// One list slot: holds a key, compares it, loads its neighbor's key on shift.
// ---------------------------------------------------------------------------
module mhl_cell import mhl_pkg::*; (
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  key_t      shift_in,
  output key_t      key_q,
  output logic      match
);

  key_t key_r;

  // Take the key of the slot in front on a shift
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      key_r <= shift_in;
    end
  end

  // Compare the held key with the searched one
  assign match = (key_r == ctl.cmp_key);
  assign key_q = key_r;

endmodule

// File: rtl/mhl_first_match.sv
// ---------------------------------------------------------------------------
// mhl_first_match
// Find the lowest set match bit and encode its position.
// ---------------------------------------------------------------------------
module mhl_first_match import mhl_pkg::*; (
  input  logic [DEPTH-1:0] match_vec,
  output logic             any,
  output pos_t             pos
);

  logic [DEPTH-1:0] first_oh;

  // Isolate the lowest set bit
  assign first_oh = match_vec & (~match_vec + DEPTH'(1));
  assign any      = |match_vec;

  // OR-encode the one-hot position
  always_comb begin
    pos = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (first_oh[i]) begin
        pos = pos | POS_W'(i);
      end
    end
  end

endmodule

// File: rtl/mru_history_list_core.sv
// ---------------------------------------------------------------------------
// mru_history_list_core
// Most-recently-used key list built as a chain of compare-and-shift cells.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries one contact key per beat. Every
//   beat gives exactly one result beat on out_valid/out_ready: hit flag, hit
//   position, eviction flag and key, and occupancy after the access.
//   cfg_wr_en/cfg_wr_data set the capacity in use; write it only while idle.
//   A capacity of zero leaves the list untouched.
// Throughput:
//   The result is registered. One beat per cycle is sustained while out_ready
//   is high: every cell compares its key against the input, and the cells up
//   to the hit or insert position shift in their neighbor's key in the same
//   cycle that the beat is taken. The path is bounded by the key compare, the
//   first-match search over the cells and the per-cell load decision.
// Reset:
//   rst_n (synchronous, active low) empties the list and clears the capacity
//   to zero. Cell contents are not cleared; slots at or above the count are
//   never read.
// Stall:
//   A valid result holds while out_ready is low; in_ready then drops
//   and the input waits. A beat is taken when out_ready frees the register.
// ---------------------------------------------------------------------------
`include "mru_history_list_core_defines.svh"

module mru_history_list_core import mhl_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  // input channel
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [IN_KEY_W-1:0] in_contact_key,
  // result channel
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_hit,
  output logic [HPOS_W-1:0]   out_hit_position,
  output logic                out_evicted,
  output logic [IN_KEY_W-1:0] out_evicted_key,
  output logic [CNT_W-1:0]    out_occupancy,
  // configuration
  input  logic                cfg_wr_en,
  input  logic [CFG_W-1:0]    cfg_wr_data
);

  logic [CFG_W-1:0] max_entries_r;
  cnt_t             entry_count_r, entry_count_nxt;
  logic             out_valid_r;

  logic             accept;
  logic             enable;
  key_t             key_in;
  cnt_t             cap;
  logic             full;
  cnt_t             count_trunc;
  pos_t             limit;
  pos_t             ev_idx;
  key_t             cell_key [DEPTH];
  logic [DEPTH-1:0] cell_match;
  logic [DEPTH-1:0] valid_match;
  logic             hit;
  pos_t             hit_pos;
  cell_ctl_t        cell_ctl [DEPTH];

  logic                out_hit_r;
  logic [HPOS_W-1:0]   out_hit_position_r;
  logic                out_evicted_r;
  logic [IN_KEY_W-1:0] out_evicted_key_r;
  cnt_t                out_occupancy_r;

  // Handshake: take a beat when the output register is free or draining
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  // Capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_entries_r <= '0;
    end else if (cfg_wr_en) begin
      max_entries_r <= cfg_wr_data;
    end
  end

  // Saturate capacity at the number of cells
  assign cap    = (CNT_W'(max_entries_r) > CNT_W'(DEPTH)) ? CNT_W'(DEPTH)
                                                         : CNT_W'(max_entries_r);
  assign enable = (cap != '0);
  assign key_in = key_t'(in_contact_key);

  // Cell chain: cell 0 takes the new key, others take their neighbor
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    key_t shift_src;
    if (i == 0) begin : g_head
      assign shift_src = key_in;
    end else begin : g_body
      assign shift_src = cell_key[i-1];
    end

    assign cell_ctl[i].cmp_key = key_in;
    assign cell_ctl[i].load    = accept && enable && (POS_W'(i) <= limit);
    assign valid_match[i]      = cell_match[i] && (CNT_W'(i) < entry_count_r);

    mhl_cell u_cell (
      .clk      (clk),
      .ctl      (cell_ctl[i]),
      .shift_in (shift_src),
      .key_q    (cell_key[i]),
      .match    (cell_match[i])
    );
  end

  // Locate the most recent matching slot
  mhl_first_match u_first_match (
    .match_vec (valid_match),
    .any       (hit),
    .pos       (hit_pos)
  );

  // Miss on a full list: cut to capacity-1 before the insert
  assign full        = (entry_count_r >= cap);
  assign count_trunc = full ? (cap - CNT_W'(1)) : entry_count_r;
  assign limit       = hit ? hit_pos : POS_W'(count_trunc);
  assign ev_idx      = POS_W'(entry_count_r - CNT_W'(1));

  // Advance the count on an insert
  always_comb begin
    entry_count_nxt = entry_count_r;
    if (accept && enable && !hit) begin
      entry_count_nxt = full ? cap : (entry_count_r + CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= '0;
    end else begin
      entry_count_r <= entry_count_nxt;
    end
  end

  // Result valid: set on accept, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload: load on accept, hold otherwise
  always_ff @(posedge clk) begin
    if (accept) begin
      out_hit_r          <= enable && hit;
      out_hit_position_r <= (enable && hit) ? HPOS_W'(hit_pos) : '0;
      out_evicted_r      <= enable && !hit && full;
      out_evicted_key_r  <= (enable && !hit && full) ? IN_KEY_W'(cell_key[ev_idx]) : '0;
      out_occupancy_r    <= entry_count_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_hit          = out_hit_r;
  assign out_hit_position = out_hit_position_r;
  assign out_evicted      = out_evicted_r;
  assign out_evicted_key  = out_evicted_key_r;
  assign out_occupancy    = out_occupancy_r;

  // Checks
  `MHL_ASSERT_NOW(a_hit_no_evict, out_valid, !(out_hit && out_evicted),
    "hit and eviction in the same beat")
  `MHL_ASSERT_NOW(a_hit_below_occ, out_valid && out_hit,
    CNT_W'(out_hit_position) < out_occupancy, "hit position beyond occupancy")
  `MHL_ASSERT_NOW(a_evict_key_zero, out_valid && !out_evicted,
    out_evicted_key == '0, "evicted key set without eviction")
  `MHL_ASSERT_NEXT(a_accept_result, accept, out_valid_r,
    "accepted beat produced no result")

endmodule
